### design/rfdp_pkg.sv
// Shared types, constants and helpers for the radar frame distance parser.
// No dependencies; every other design file refers to it by scoped names.
package rfdp_pkg;

    localparam int ERR_CNT_W = 16;   // error counter width, saturating
    localparam int BYTE_W    = 8;
    localparam int DIST_W    = 16;
    localparam int ERR_OUT_W = 16;   // width of the reported counter fields

    localparam logic [BYTE_W-1:0] BYTE_HEAD      = 8'hAA;
    localparam logic [BYTE_W-1:0] BYTE_TYPE_STAT = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_TYPE_TGT  = 8'h0B;
    localparam logic [BYTE_W-1:0] BYTE_TYPE_DIST = 8'h0C;
    localparam logic [BYTE_W-1:0] BYTE_LEN_STAT  = 8'h06;
    localparam logic [BYTE_W-1:0] BYTE_LEN_LONG  = 8'h07;
    localparam logic [BYTE_W-1:0] BYTE_PAY_START = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_STAT_LO   = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_STAT_HI   = 8'h13;
    localparam logic [BYTE_W-1:0] BYTE_TGT_HI    = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_FILL      = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_TAIL      = 8'h55;

    localparam logic [2:0] PAY_LAST_CNT = 3'd6;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_STAT = 2'd1,
        KIND_TGT  = 2'd2,
        KIND_DIST = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_HEAD0      = 4'd0,
        PH_HEAD1      = 4'd1,
        PH_TYPE       = 4'd2,
        PH_LEN_STAT   = 4'd3,
        PH_LEN_LONG   = 4'd4,
        PH_PAY_FIRST  = 4'd5,
        PH_PAY_SECOND = 4'd6,
        PH_PAY_FILL   = 4'd7,
        PH_CSUM       = 4'd8,
        PH_TAIL0      = 4'd9,
        PH_DIST_HI    = 4'd10,
        PH_DIST_LO    = 4'd11,
        PH_PAY_REST   = 4'd12,
        PH_TAIL1      = 4'd13
    } phase_t;

    typedef logic [ERR_CNT_W-1:0] err_cnt_t;

    typedef struct packed {
        kind_t                  frame_done;
        logic                   distance_valid;
        logic [DIST_W-1:0]      range_cm;
        logic [ERR_OUT_W-1:0]   head_errors;
        logic [ERR_OUT_W-1:0]   invalid_errors;
        logic [ERR_OUT_W-1:0]   payload_errors;
        logic [ERR_OUT_W-1:0]   tail_errors;
    } res_t;

    function automatic err_cnt_t sat_inc(input err_cnt_t c);
        return (c == '1) ? c : c + ERR_CNT_W'(1);
    endfunction

    // low bits of a counter, zero-extended when the counter is narrower
    function automatic logic [ERR_OUT_W-1:0] cnt_out(input err_cnt_t c);
        logic [ERR_CNT_W+ERR_OUT_W-1:0] ext;
        ext = {{ERR_OUT_W{1'b0}}, c};
        return ext[ERR_OUT_W-1:0];
    endfunction

endpackage

### design/rfdp_if.sv
// Handshake channels of the radar frame distance parser: byte in, result out.
// Depends on rfdp_pkg for widths.
interface rfdp_in_if;
    logic                        valid;
    logic                        ready;
    logic [rfdp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfdp_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     frame_done;
    logic                           distance_valid;
    logic [rfdp_pkg::DIST_W-1:0]    range_cm;
    logic [rfdp_pkg::ERR_OUT_W-1:0] head_errors;
    logic [rfdp_pkg::ERR_OUT_W-1:0] invalid_errors;
    logic [rfdp_pkg::ERR_OUT_W-1:0] payload_errors;
    logic [rfdp_pkg::ERR_OUT_W-1:0] tail_errors;

    modport source (output valid, output frame_done, output distance_valid,
                    output range_cm, output head_errors, output invalid_errors,
                    output payload_errors, output tail_errors, input ready);
    modport sink   (input valid, input frame_done, input distance_valid,
                    input range_cm, input head_errors, input invalid_errors,
                    input payload_errors, input tail_errors, output ready);
endinterface

### design/rfdp_parse.sv
// Frame parser state machine: phase, frame kind, checksum, distance, counters.
// Depends on rfdp_pkg. State advances on step; res is the result for rx_byte.
module rfdp_parse (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [rfdp_pkg::BYTE_W-1:0] rx_byte,
    output rfdp_pkg::res_t              res
);

    rfdp_pkg::phase_t               phase_reg, phase_next;
    rfdp_pkg::kind_t                kind_reg, kind_next;
    logic [2:0]                     cnt_reg, cnt_next;
    logic [rfdp_pkg::BYTE_W-1:0]    sum_reg, sum_next;
    logic [rfdp_pkg::DIST_W-1:0]    dist_reg, dist_next;
    rfdp_pkg::err_cnt_t             head_reg, head_next;
    rfdp_pkg::err_cnt_t             inv_reg, inv_next;
    rfdp_pkg::err_cnt_t             pay_reg, pay_next;
    rfdp_pkg::err_cnt_t             tail_reg, tail_next;
    logic                           take;
    logic                           fail;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        dist_next  = dist_reg;
        head_next  = head_reg;
        inv_next   = inv_reg;
        pay_next   = pay_reg;
        tail_next  = tail_reg;
        take       = 1'b0;
        fail       = 1'b0;

        unique case (phase_reg)
            rfdp_pkg::PH_HEAD0:
            begin
                if (rx_byte == rfdp_pkg::BYTE_HEAD)
                begin
                    head_next  = '0;
                    inv_next   = '0;
                    pay_next   = '0;
                    tail_next  = '0;
                    cnt_next   = '0;
                    phase_next = rfdp_pkg::PH_HEAD1;
                end
                else
                begin
                    head_next = rfdp_pkg::sat_inc(head_reg);
                end
            end
            rfdp_pkg::PH_HEAD1:
            begin
                if (rx_byte == rfdp_pkg::BYTE_HEAD)
                begin
                    phase_next = rfdp_pkg::PH_TYPE;
                end
                else
                begin
                    head_next  = rfdp_pkg::sat_inc(head_reg);
                    phase_next = rfdp_pkg::PH_HEAD0;
                end
            end
            rfdp_pkg::PH_TYPE:
            begin
                priority if (rx_byte == rfdp_pkg::BYTE_TYPE_STAT)
                begin
                    kind_next  = rfdp_pkg::KIND_STAT;
                    phase_next = rfdp_pkg::PH_LEN_STAT;
                end
                else if (rx_byte == rfdp_pkg::BYTE_TYPE_TGT
                         && kind_reg == rfdp_pkg::KIND_STAT)
                begin
                    kind_next  = rfdp_pkg::KIND_TGT;
                    phase_next = rfdp_pkg::PH_LEN_LONG;
                end
                else if (rx_byte == rfdp_pkg::BYTE_TYPE_DIST
                         && kind_reg == rfdp_pkg::KIND_TGT)
                begin
                    kind_next  = rfdp_pkg::KIND_DIST;
                    phase_next = rfdp_pkg::PH_LEN_LONG;
                end
                else
                begin
                    inv_next   = rfdp_pkg::sat_inc(inv_reg);
                    phase_next = rfdp_pkg::PH_HEAD0;
                end
            end
            rfdp_pkg::PH_LEN_STAT, rfdp_pkg::PH_LEN_LONG:
            begin
                if (rx_byte == ((phase_reg == rfdp_pkg::PH_LEN_STAT)
                                ? rfdp_pkg::BYTE_LEN_STAT : rfdp_pkg::BYTE_LEN_LONG))
                begin
                    phase_next = rfdp_pkg::PH_PAY_FIRST;
                end
                else
                begin
                    inv_next   = rfdp_pkg::sat_inc(inv_reg);
                    phase_next = rfdp_pkg::PH_HEAD0;
                end
            end
            rfdp_pkg::PH_PAY_FIRST:
            begin
                if (rx_byte == rfdp_pkg::BYTE_PAY_START)
                begin
                    take       = 1'b1;
                    phase_next = rfdp_pkg::PH_PAY_SECOND;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            rfdp_pkg::PH_PAY_SECOND:
            begin
                priority if (kind_reg == rfdp_pkg::KIND_STAT
                             && rx_byte >= rfdp_pkg::BYTE_STAT_LO
                             && rx_byte <= rfdp_pkg::BYTE_STAT_HI)
                begin
                    take       = 1'b1;
                    phase_next = rfdp_pkg::PH_PAY_FILL;
                end
                else if (kind_reg == rfdp_pkg::KIND_TGT && rx_byte <= rfdp_pkg::BYTE_TGT_HI)
                begin
                    take       = 1'b1;
                    phase_next = rfdp_pkg::PH_PAY_FILL;
                end
                else if (kind_reg == rfdp_pkg::KIND_DIST)
                begin
                    take       = 1'b1;
                    phase_next = rfdp_pkg::PH_DIST_HI;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            rfdp_pkg::PH_PAY_FILL, rfdp_pkg::PH_PAY_REST:
            begin
                priority if (cnt_reg == rfdp_pkg::PAY_LAST_CNT)
                begin
                    take       = 1'b1;
                    phase_next = rfdp_pkg::PH_CSUM;
                end
                else if (cnt_reg < rfdp_pkg::PAY_LAST_CNT
                         && (phase_reg == rfdp_pkg::PH_PAY_REST
                             || rx_byte == rfdp_pkg::BYTE_FILL))
                begin
                    take = 1'b1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            rfdp_pkg::PH_CSUM:
            begin
                if (rx_byte == sum_reg)
                begin
                    phase_next = rfdp_pkg::PH_TAIL0;
                end
                else
                begin
                    inv_next   = rfdp_pkg::sat_inc(inv_reg);
                    phase_next = rfdp_pkg::PH_HEAD0;
                end
            end
            rfdp_pkg::PH_TAIL0, rfdp_pkg::PH_TAIL1:
            begin
                if (rx_byte == rfdp_pkg::BYTE_TAIL)
                begin
                    phase_next = (phase_reg == rfdp_pkg::PH_TAIL0)
                                 ? rfdp_pkg::PH_TAIL1 : rfdp_pkg::PH_HEAD0;
                end
                else
                begin
                    tail_next  = rfdp_pkg::sat_inc(tail_reg);
                    phase_next = rfdp_pkg::PH_HEAD0;
                end
            end
            rfdp_pkg::PH_DIST_HI:
            begin
                dist_next  = {rx_byte, {rfdp_pkg::DIST_W-rfdp_pkg::BYTE_W{1'b0}}};
                take       = 1'b1;
                phase_next = rfdp_pkg::PH_DIST_LO;
            end
            rfdp_pkg::PH_DIST_LO:
            begin
                dist_next  = {dist_reg[rfdp_pkg::DIST_W-1 -: rfdp_pkg::BYTE_W], rx_byte};
                take       = 1'b1;
                phase_next = rfdp_pkg::PH_PAY_REST;
            end
            default:
            begin
                phase_next = rfdp_pkg::PH_HEAD0;
            end
        endcase

        if (take)
        begin
            // the start byte restarts the checksum
            sum_next = (phase_reg == rfdp_pkg::PH_PAY_FIRST) ? rx_byte : sum_reg + rx_byte;
            cnt_next = cnt_reg + 3'd1;
        end
        if (fail)
        begin
            pay_next   = rfdp_pkg::sat_inc(pay_reg);
            phase_next = rfdp_pkg::PH_HEAD0;
        end
    end

    // result for the byte being stepped
    always_comb
    begin
        res = '0;
        if (phase_reg == rfdp_pkg::PH_TAIL1 && rx_byte == rfdp_pkg::BYTE_TAIL)
        begin
            res.frame_done = kind_reg;
        end
        if (res.frame_done == rfdp_pkg::KIND_DIST)
        begin
            res.distance_valid = 1'b1;
            res.range_cm       = dist_reg;
        end
        res.head_errors    = rfdp_pkg::cnt_out(head_next);
        res.invalid_errors = rfdp_pkg::cnt_out(inv_next);
        res.payload_errors = rfdp_pkg::cnt_out(pay_next);
        res.tail_errors    = rfdp_pkg::cnt_out(tail_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfdp_pkg::PH_HEAD0;
            kind_reg  <= rfdp_pkg::KIND_NONE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            dist_reg  <= '0;
            head_reg  <= '0;
            inv_reg   <= '0;
            pay_reg   <= '0;
            tail_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            dist_reg  <= dist_next;
            head_reg  <= head_next;
            inv_reg   <= inv_next;
            pay_reg   <= pay_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

### design/radar_frame_distance_parser_top.sv
// Top level of the radar frame distance parser: input register, parser, result register.
// Depends on rfdp_pkg, rfdp_in_if, rfdp_out_if and rfdp_parse.

// One received byte per item, one result item per byte. The block takes a byte in
// every cycle while results are taken; a byte is parsed from the input register and
// its result is loaded into the result register when that register is free or its
// result is taken. The rate is set by the combinational parse step between the
// two registers. When the result is not taken the input register still accepts one
// further byte. The counters reported with each result are the values after that
// byte; a first header byte AA while waiting for a frame clears all four.
module radar_frame_distance_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    rfdp_in_if.sink             din,
    rfdp_out_if.source          dout
);

    logic                        s1_valid_reg;
    logic [rfdp_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        out_valid_reg;
    rfdp_pkg::res_t              out_res_reg;
    rfdp_pkg::res_t              parse_res;
    logic                        out_free;
    logic                        s1_adv;

    assign out_free = !out_valid_reg || dout.ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign din.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            s1_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.ready && din.valid)
        begin
            s1_byte_reg <= din.rx_byte;
        end
    end

    rfdp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_adv),
        .rx_byte (s1_byte_reg),
        .res     (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_res_reg <= parse_res;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.frame_done     = out_res_reg.frame_done;
    assign dout.distance_valid = out_res_reg.distance_valid;
    assign dout.range_cm       = out_res_reg.range_cm;
    assign dout.head_errors    = out_res_reg.head_errors;
    assign dout.invalid_errors = out_res_reg.invalid_errors;
    assign dout.payload_errors = out_res_reg.payload_errors;
    assign dout.tail_errors    = out_res_reg.tail_errors;

    // a distance is flagged exactly for distance frames
    a_dist_flag: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.distance_valid == (dout.frame_done == rfdp_pkg::KIND_DIST)))
        else $error("distance_valid disagrees with frame_done");

    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.distance_valid) |-> (dout.range_cm == '0))
        else $error("range_cm not zero without a distance frame");

    // a held byte in the input register must not be lost or altered
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input register dropped a waiting byte");

endmodule

### bench/radar_frame_distance_parser_top_tb.sv
// Testbench for radar_frame_distance_parser_top: drives received bytes, checks every result
// item against a built-in parser model or a table row. Depends on rfdp_pkg and rfdp_if.sv.
`timescale 1ns / 100ps

module radar_frame_distance_parser_top_tb;

    localparam int N_RANDOM    = 1150;
    localparam int N_DIRECTED  = 26;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0]     rx;
        logic           typed;
        rfdp_pkg::res_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rfdp_in_if  din_ch ();
    rfdp_out_if dout_ch ();

    radar_frame_distance_parser_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    always #5 clk = ~clk;

    // parser model state
    rfdp_pkg::phase_t ph;
    rfdp_pkg::kind_t  kind;
    logic [2:0]       pay_cnt;
    logic [7:0]       pay_sum;
    logic [15:0]      dist_acc;
    logic [15:0]      head_cnt, invalid_cnt, payload_cnt, tail_cnt;

    rfdp_pkg::res_t pending_results [$];
    int   mismatch_count = 0;
    int   bytes_sent = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;

    // short directed walk: head errors, clear, bad length, bad target byte,
    // then a distance frame with the largest distance
    row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b1, '{rfdp_pkg::KIND_NONE, 1'b0, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0}},
        '{8'hFF, 1'b1, '{rfdp_pkg::KIND_NONE, 1'b0, 16'h0000, 16'd2, 16'd0, 16'd0, 16'd0}},
        '{8'hAA, 1'b1, '{rfdp_pkg::KIND_NONE, 1'b0, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0}},
        '{8'hAA, 1'b0, '0},
        '{8'h0A, 1'b0, '0},
        '{8'h05, 1'b1, '{rfdp_pkg::KIND_NONE, 1'b0, 16'h0000, 16'd0, 16'd1, 16'd0, 16'd0}},
        '{8'hAA, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h0B, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h04, 1'b1, '{rfdp_pkg::KIND_NONE, 1'b0, 16'h0000, 16'd0, 16'd0, 16'd1, 16'd0}},
        '{8'hAA, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h0C, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFB, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h55, 1'b1, '{rfdp_pkg::KIND_DIST, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0}}
    };

    function automatic logic [15:0] sat_bump(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic void absorb_payload(input logic [7:0] b, input rfdp_pkg::phase_t nxt);
        pay_sum = pay_sum + b;
        pay_cnt = pay_cnt + 3'd1;
        ph      = nxt;
    endfunction

    function automatic rfdp_pkg::res_t parse_byte(input logic [7:0] b);
        rfdp_pkg::res_t  r;
        rfdp_pkg::kind_t done;
        done = rfdp_pkg::KIND_NONE;
        case (ph)
            rfdp_pkg::PH_HEAD0:
                if (b == rfdp_pkg::BYTE_HEAD)
                begin
                    head_cnt    = '0;
                    invalid_cnt = '0;
                    payload_cnt = '0;
                    tail_cnt    = '0;
                    pay_cnt     = '0;
                    ph          = rfdp_pkg::PH_HEAD1;
                end
                else
                    head_cnt = sat_bump(head_cnt);
            rfdp_pkg::PH_HEAD1:
                if (b == rfdp_pkg::BYTE_HEAD)
                    ph = rfdp_pkg::PH_TYPE;
                else
                begin
                    head_cnt = sat_bump(head_cnt);
                    ph       = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_TYPE:
                if (b == rfdp_pkg::BYTE_TYPE_STAT)
                begin
                    kind = rfdp_pkg::KIND_STAT;
                    ph   = rfdp_pkg::PH_LEN_STAT;
                end
                else if (b == rfdp_pkg::BYTE_TYPE_TGT && kind == rfdp_pkg::KIND_STAT)
                begin
                    kind = rfdp_pkg::KIND_TGT;
                    ph   = rfdp_pkg::PH_LEN_LONG;
                end
                else if (b == rfdp_pkg::BYTE_TYPE_DIST && kind == rfdp_pkg::KIND_TGT)
                begin
                    kind = rfdp_pkg::KIND_DIST;
                    ph   = rfdp_pkg::PH_LEN_LONG;
                end
                else
                begin
                    invalid_cnt = sat_bump(invalid_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_LEN_STAT, rfdp_pkg::PH_LEN_LONG:
                if (b == ((ph == rfdp_pkg::PH_LEN_STAT)
                          ? rfdp_pkg::BYTE_LEN_STAT : rfdp_pkg::BYTE_LEN_LONG))
                    ph = rfdp_pkg::PH_PAY_FIRST;
                else
                begin
                    invalid_cnt = sat_bump(invalid_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_PAY_FIRST:
                if (b == rfdp_pkg::BYTE_PAY_START)
                begin
                    pay_sum = '0;
                    absorb_payload(b, rfdp_pkg::PH_PAY_SECOND);
                end
                else
                begin
                    payload_cnt = sat_bump(payload_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_PAY_SECOND:
                if (kind == rfdp_pkg::KIND_STAT && b >= rfdp_pkg::BYTE_STAT_LO
                    && b <= rfdp_pkg::BYTE_STAT_HI)
                    absorb_payload(b, rfdp_pkg::PH_PAY_FILL);
                else if (kind == rfdp_pkg::KIND_TGT && b <= rfdp_pkg::BYTE_TGT_HI)
                    absorb_payload(b, rfdp_pkg::PH_PAY_FILL);
                else if (kind == rfdp_pkg::KIND_DIST)
                    absorb_payload(b, rfdp_pkg::PH_DIST_HI);
                else
                begin
                    payload_cnt = sat_bump(payload_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_PAY_FILL, rfdp_pkg::PH_PAY_REST:
                // last payload byte is free; before it, status and target fill must be zero
                if (pay_cnt == rfdp_pkg::PAY_LAST_CNT)
                    absorb_payload(b, rfdp_pkg::PH_CSUM);
                else if (pay_cnt < rfdp_pkg::PAY_LAST_CNT
                         && (ph == rfdp_pkg::PH_PAY_REST || b == rfdp_pkg::BYTE_FILL))
                    absorb_payload(b, ph);
                else
                begin
                    payload_cnt = sat_bump(payload_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_CSUM:
                if (b == pay_sum)
                    ph = rfdp_pkg::PH_TAIL0;
                else
                begin
                    invalid_cnt = sat_bump(invalid_cnt);
                    ph          = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_TAIL0, rfdp_pkg::PH_TAIL1:
                if (b == rfdp_pkg::BYTE_TAIL)
                begin
                    if (ph == rfdp_pkg::PH_TAIL0)
                        ph = rfdp_pkg::PH_TAIL1;
                    else
                    begin
                        ph   = rfdp_pkg::PH_HEAD0;
                        done = kind;
                    end
                end
                else
                begin
                    tail_cnt = sat_bump(tail_cnt);
                    ph       = rfdp_pkg::PH_HEAD0;
                end
            rfdp_pkg::PH_DIST_HI:
            begin
                dist_acc = {b, 8'h00};
                absorb_payload(b, rfdp_pkg::PH_DIST_LO);
            end
            rfdp_pkg::PH_DIST_LO:
            begin
                dist_acc[7:0] = b;
                absorb_payload(b, rfdp_pkg::PH_PAY_REST);
            end
            default:
                ph = rfdp_pkg::PH_HEAD0;
        endcase

        r.frame_done     = done;
        r.distance_valid = (done == rfdp_pkg::KIND_DIST);
        r.range_cm       = (done == rfdp_pkg::KIND_DIST) ? dist_acc : 16'h0000;
        r.head_errors    = head_cnt;
        r.invalid_errors = invalid_cnt;
        r.payload_errors = payload_cnt;
        r.tail_errors    = tail_cnt;
        return r;
    endfunction

    // one item on the byte channel; the expectation is queued at acceptance
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input rfdp_pkg::res_t want);
        rfdp_pkg::res_t model;
        while ($urandom_range(99) < gap_pct)
        begin
            din_ch.valid <= 1'b0;
            @(posedge clk);
        end
        din_ch.valid   <= 1'b1;
        din_ch.rx_byte <= b;
        @(posedge clk);
        while (!din_ch.ready)
            @(posedge clk);
        model = parse_byte(b);
        pending_results.push_back(typed ? want : model);
        bytes_sent++;
    endtask

    task automatic send_frame();
        logic [7:0] fb [$];
        logic [7:0] ty;
        logic [7:0] csum;
        int         sel;
        case (kind)
            rfdp_pkg::KIND_STAT: ty = rfdp_pkg::BYTE_TYPE_TGT;
            rfdp_pkg::KIND_TGT:  ty = rfdp_pkg::BYTE_TYPE_DIST;
            default:             ty = rfdp_pkg::BYTE_TYPE_STAT;
        endcase
        if ($urandom_range(9) == 0)
            ty = rfdp_pkg::BYTE_TYPE_STAT + 8'($urandom_range(2));
        fb = {rfdp_pkg::BYTE_HEAD, rfdp_pkg::BYTE_HEAD, ty,
              (ty == rfdp_pkg::BYTE_TYPE_STAT) ? rfdp_pkg::BYTE_LEN_STAT
                                               : rfdp_pkg::BYTE_LEN_LONG,
              rfdp_pkg::BYTE_PAY_START};
        if (ty == rfdp_pkg::BYTE_TYPE_DIST)
        begin
            fb.push_back(8'($urandom_range(255)));
            sel = $urandom_range(3);
            if (sel == 0)
                fb = {fb, 8'h00, 8'h00};
            else if (sel == 1)
                fb = {fb, 8'hFF, 8'hFF};
            else
                fb = {fb, 8'($urandom_range(255)), 8'($urandom_range(255))};
            repeat (3)
                fb.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if (ty == rfdp_pkg::BYTE_TYPE_STAT)
                fb.push_back(rfdp_pkg::BYTE_STAT_LO + 8'($urandom_range(3)));
            else
                fb.push_back(8'($urandom_range(3)));
            repeat (4)
                fb.push_back(rfdp_pkg::BYTE_FILL);
            fb.push_back(8'($urandom_range(255)));
        end
        csum = '0;
        for (int i = 4; i < 11; i++)
            csum = csum + fb[i];
        fb = {fb, csum, rfdp_pkg::BYTE_TAIL, rfdp_pkg::BYTE_TAIL};
        // broken frames: one byte anywhere replaced
        if ($urandom_range(3) == 0)
            fb[$urandom_range(fb.size() - 1)] = 8'($urandom_range(255));
        foreach (fb[i])
            send_byte(fb[i], 1'b0, '0);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(7) == 0) ? rfdp_pkg::BYTE_HEAD
                                                       : 8'($urandom_range(255)),
                              1'b0, '0);
            else
                send_frame();
        end
    endtask

    task automatic drain();
        din_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        dout_ch.ready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge clk)
    begin
        rfdp_pkg::res_t want;
        rfdp_pkg::res_t got;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            got.frame_done     = rfdp_pkg::kind_t'(dout_ch.frame_done);
            got.distance_valid = dout_ch.distance_valid;
            got.range_cm       = dout_ch.range_cm;
            got.head_errors    = dout_ch.head_errors;
            got.invalid_errors = dout_ch.invalid_errors;
            got.payload_errors = dout_ch.payload_errors;
            got.tail_errors    = dout_ch.tail_errors;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result item with none expected: done=%0d dist=%h", $realtime,
                             got.frame_done, got.range_cm);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.frame_done !== want.frame_done
                    || got.distance_valid !== want.distance_valid
                    || got.range_cm !== want.range_cm
                    || got.head_errors !== want.head_errors
                    || got.invalid_errors !== want.invalid_errors
                    || got.payload_errors !== want.payload_errors
                    || got.tail_errors !== want.tail_errors)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: mismatch exp done=%0d dv=%0b dist=%h err=%h/%h/%h/%h",
                                 $realtime, want.frame_done, want.distance_valid,
                                 want.range_cm, want.head_errors, want.invalid_errors,
                                 want.payload_errors, want.tail_errors,
                                 "\n                    got done=%0d dv=%0b dist=%h err=%h/%h/%h/%h",
                                 got.frame_done, got.distance_valid, got.range_cm,
                                 got.head_errors, got.invalid_errors, got.payload_errors,
                                 got.tail_errors);
                end
            end
        end
    end

    initial
    begin
        ph          = rfdp_pkg::PH_HEAD0;
        kind        = rfdp_pkg::KIND_NONE;
        pay_cnt     = '0;
        pay_sum     = '0;
        dist_acc    = '0;
        head_cnt    = '0;
        invalid_cnt = '0;
        payload_cnt = '0;
        tail_cnt    = '0;
        din_ch.valid   <= 1'b0;
        din_ch.rx_byte <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

        run_random(N_RANDOM / 4);
        drain();

        gap_pct = 47;
        run_random(N_RANDOM / 4);
        drain();

        gap_pct   = 0;
        stall_pct = 47;
        run_random(N_RANDOM / 4);

        gap_pct   = 30;
        stall_pct = 30;
        run_random(N_RANDOM / 4);

        drain();
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // about 1200 items need well under 100 us; this allows far more
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/rfdp_pkg.sv
design/rfdp_if.sv
design/rfdp_parse.sv
design/radar_frame_distance_parser_top.sv
bench/radar_frame_distance_parser_top_tb.sv
